@@ rtl/lpmq_pkg.sv @@
// Package with shared types and constants of the length-prefixed message queue.
`default_nettype none

package lpmq_pkg;

    localparam int DEPTH   = 256;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = BYTE_W + 1;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_PEEK  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_ROOM    = 3'd1,
        STS_EMPTY      = 3'd2,
        STS_STRAY      = 3'd3,
        STS_PEEK_RANGE = 3'd4,
        STS_INCOMPLETE = 3'd5,
        STS_BUSY       = 3'd6
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } lpmq_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } ring_req_t;

endpackage

`default_nettype wire

@@ rtl/lpmq_ring.sv @@
// Byte ring storage with one write port and one registered read port.
`default_nettype none

module lpmq_ring
(
    input  wire logic                       clk,
    input  wire lpmq_pkg::ring_req_t        req,
    output logic [lpmq_pkg::BYTE_W-1:0]     rd_data
);
    import lpmq_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/length_prefixed_message_queue_core.sv @@
// Top level of the length-prefixed message queue: command decode, indexes and result register.
//
// Commands arrive on the s_ channel, one word each: start a message, append a data
// byte, pop the oldest message or peek at a queued byte. Every accepted word gives
// exactly one result word on the m_ channel with a status code, the peeked byte, the
// empty flag and the count of free bytes in the ring.
// Start and data words are done at the accepting edge: the ring is written and the
// result register loaded there. Pop and peek words pass through the execute state,
// because the byte they need comes out of the ring memory in the cycle after its address is presented.
// In the idle state a new word is taken while the previous result waits, as long
// as that result is taken in the same cycle or the result register is empty; a
// stalled receiver holds the result and keeps s_tready low until the result is taken.
// Reset clears the state, the indexes, the open message state and the result valid
// flag; the ring contents stay undefined and are only ever used where they were written.
`default_nettype none

module length_prefixed_message_queue_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // msg_length [7:0], data_byte [15:8], peek_offset [23:16]
    input  wire logic [lpmq_pkg::S_DATA_W-1:0]     s_tdata,
    // command [1:0]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // peek_data [7:0], queue_empty [8], free_bytes [16:9], zero [23:17]
    output logic [lpmq_pkg::M_DATA_W-1:0]          m_tdata,
    // status [2:0]
    output logic [2:0]                             m_tuser
);
    import lpmq_pkg::*;

    lpmq_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [BYTE_W-1:0] remain_reg, remain_next;
    logic              open_reg, open_next;
    cmd_t              cmd_reg, cmd_next;
    logic              peek_bad_reg, peek_bad_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [BYTE_W-1:0] out_peek_reg, out_peek_next;
    logic              out_empty_reg, out_empty_next;
    logic [BYTE_W-1:0] out_free_reg, out_free_next;

    ring_req_t         ring_req;
    logic [BYTE_W-1:0] ring_rd_data;

    logic              accept;
    logic              out_free_slot;
    cmd_t              in_cmd;
    logic [BYTE_W-1:0] in_length;
    logic [BYTE_W-1:0] in_data;
    logic [BYTE_W-1:0] in_offset;
    logic [IDX_W-1:0]  queued;
    logic [IDX_W-1:0]  free_cnt;
    logic [IDX_W-1:0]  step_free;
    logic              done;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_length = s_tdata[7:0];
    assign in_data   = s_tdata[15:8];
    assign in_offset = s_tdata[23:16];

    assign queued   = wr_idx_reg - rd_idx_reg;
    assign free_cnt = rd_idx_reg - wr_idx_reg - IDX_W'(1);

    assign out_free_slot = !out_valid_reg || m_tready;
    assign accept        = s_tvalid && s_tready;

    lpmq_ring u_ring
    (
        .clk     (clk),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_POP || in_cmd == CMD_PEEK))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free_slot;
            end
            ST_EXEC:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        remain_next     = remain_reg;
        open_next       = open_reg;
        cmd_next        = cmd_reg;
        peek_bad_next   = peek_bad_reg;
        out_status_next = out_status_reg;
        out_peek_next   = out_peek_reg;
        out_empty_next  = out_empty_reg;
        out_free_next   = out_free_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ring_req        = '0;
        done            = 1'b0;
        out_status_next = STS_OK;

        if (state_reg == ST_IDLE && accept)
        begin
            cmd_next        = in_cmd;
            peek_bad_next   = ({1'b0, in_offset} >= CNT_W'(queued));
            ring_req.rd_en  = 1'b1;
            ring_req.rd_addr = rd_idx_reg + IDX_W'(1);
            case (in_cmd)
                CMD_START:
                begin
                    done = 1'b1;
                    if (open_reg)
                    begin
                        out_status_next = STS_BUSY;
                    end
                    else if (CNT_W'(free_cnt) < ({1'b0, in_length} + CNT_W'(1)))
                    begin
                        out_status_next = STS_NO_ROOM;
                    end
                    else
                    begin
                        wr_idx_next      = wr_idx_reg + IDX_W'(1);
                        ring_req.wr_en   = 1'b1;
                        ring_req.wr_addr = wr_idx_next;
                        ring_req.wr_data = in_length;
                        remain_next      = in_length;
                        open_next        = (in_length != '0);
                    end
                end
                CMD_DATA:
                begin
                    done = 1'b1;
                    if (!open_reg)
                    begin
                        out_status_next = STS_STRAY;
                    end
                    else
                    begin
                        wr_idx_next      = wr_idx_reg + IDX_W'(1);
                        ring_req.wr_en   = 1'b1;
                        ring_req.wr_addr = wr_idx_next;
                        ring_req.wr_data = in_data;
                        remain_next      = remain_reg - BYTE_W'(1);
                        open_next        = (remain_next != '0);
                    end
                end
                CMD_PEEK:
                begin
                    ring_req.rd_addr = rd_idx_reg + IDX_W'(1) + IDX_W'(in_offset);
                end
                default:
                begin
                    ring_req.rd_addr = rd_idx_reg + IDX_W'(1);
                end
            endcase
        end
        else if (state_reg == ST_EXEC)
        begin
            done = 1'b1;
            if (cmd_reg == CMD_PEEK)
            begin
                if (peek_bad_reg)
                begin
                    out_status_next = STS_PEEK_RANGE;
                end
                else
                begin
                    out_peek_next = ring_rd_data;
                end
            end
            else if (queued == '0)
            begin
                out_status_next = STS_EMPTY;
            end
            else if (CNT_W'(queued) < ({1'b0, ring_rd_data} + CNT_W'(1)))
            begin
                out_status_next = STS_INCOMPLETE;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(ring_rd_data) + IDX_W'(1);
            end
        end

        step_free = rd_idx_next - wr_idx_next - IDX_W'(1);
        if (done)
        begin
            out_valid_next = 1'b1;
            out_empty_next = (wr_idx_next == rd_idx_next);
            out_free_next  = BYTE_W'(step_free);
            if (!(state_reg == ST_EXEC && cmd_reg == CMD_PEEK && !peek_bad_reg))
            begin
                out_peek_next = '0;
            end
        end
        else
        begin
            out_status_next = out_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            remain_reg    <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            remain_reg    <= remain_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        peek_bad_reg   <= peek_bad_next;
        out_status_reg <= out_status_next;
        out_peek_reg   <= out_peek_next;
        out_empty_reg  <= out_empty_next;
        out_free_reg   <= out_free_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(M_DATA_W - 2 * BYTE_W - 1)'(0), out_free_reg, out_empty_reg,
                       out_peek_reg};

    // An open message always has bytes still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (remain_reg != '0))
        else $error("Open message with no bytes remaining.");

    // An open message has at least its length byte in the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (wr_idx_reg != rd_idx_reg))
        else $error("Open message in an empty ring.");

    // The execute state of a pop or peek always delivers its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> m_tvalid)
        else $error("Pop or peek finished without a result.");

    // A pop or peek blocks input while it is in the execute state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_POP || s_tuser == CMD_PEEK)) |=> !s_tready)
        else $error("Input accepted while a pop or peek is in progress.");

endmodule

`default_nettype wire

@@ tb/length_prefixed_message_queue_checker.sv @@
// Checker that predicts every result word of the message queue and compares it with the DUT.
module length_prefixed_message_queue_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // msg_length [7:0], data_byte [15:8], peek_offset [23:16]
    input  wire logic [lpmq_pkg::S_DATA_W-1:0] s_tdata,
    // command [1:0]
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // peek_data [7:0], queue_empty [8], free_bytes [16:9], zero [23:17]
    input  wire logic [lpmq_pkg::M_DATA_W-1:0] m_tdata,
    // status [2:0]
    input  wire logic [2:0]                    m_tuser,
    output int                                 fail_count,
    output int                                 results_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import lpmq_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] peek_data;
        logic              queue_empty;
        logic [BYTE_W-1:0] free_bytes;
    } queue_result_t;

    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    logic [IDX_W-1:0]  last_written;
    logic [IDX_W-1:0]  last_removed;
    logic [BYTE_W-1:0] payload_left;
    logic              msg_open;

    queue_result_t     pending_results [$];

    function automatic logic [IDX_W-1:0] bytes_queued();
        return IDX_W'(last_written - last_removed);
    endfunction

    function automatic logic [BYTE_W-1:0] bytes_free();
        return BYTE_W'(DEPTH - 1 - int'(bytes_queued()));
    endfunction

    function automatic void append_byte(logic [BYTE_W-1:0] value);
        last_written = IDX_W'(last_written + 1);
        ring_bytes[last_written] = value;
    endfunction

    // Applies one command word to the queue state and returns the result it must produce.
    function automatic queue_result_t execute_command(cmd_t cmd, logic [BYTE_W-1:0] length,
                                                      logic [BYTE_W-1:0] payload,
                                                      logic [BYTE_W-1:0] offset);
        queue_result_t     res;
        logic [BYTE_W-1:0] head_len;
        res.status    = STS_OK;
        res.peek_data = '0;
        case (cmd)
            CMD_START:
            begin
                if (msg_open)
                    res.status = STS_BUSY;
                else if ({1'b0, bytes_free()} < {1'b0, length} + 9'd1)
                    res.status = STS_NO_ROOM;
                else
                begin
                    append_byte(length);
                    payload_left = length;
                    msg_open     = (length != '0);
                end
            end
            CMD_DATA:
            begin
                if (!msg_open)
                    res.status = STS_STRAY;
                else
                begin
                    append_byte(payload);
                    payload_left = payload_left - 8'd1;
                    if (payload_left == '0)
                        msg_open = 1'b0;
                end
            end
            CMD_POP:
            begin
                if (bytes_queued() == '0)
                    res.status = STS_EMPTY;
                else
                begin
                    head_len = ring_bytes[IDX_W'(last_removed + 1)];
                    if ({1'b0, bytes_queued()} < {1'b0, head_len} + 9'd1)
                        res.status = STS_INCOMPLETE;
                    else
                        last_removed = IDX_W'(last_removed + head_len + 1);
                end
            end
            default:
            begin
                if (offset >= bytes_queued())
                    res.status = STS_PEEK_RANGE;
                else
                    res.peek_data = ring_bytes[IDX_W'(last_removed + 1 + offset)];
            end
        endcase
        res.queue_empty = (last_written == last_removed);
        res.free_bytes  = bytes_free();
        return res;
    endfunction

    always @(posedge clk)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            last_written = '0;
            last_removed = '0;
            payload_left = '0;
            msg_open     = 1'b0;
            pending_results.delete();
            fail_count   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(execute_command(cmd_t'(s_tuser), s_tdata[7:0],
                                                          s_tdata[15:8], s_tdata[23:16]));
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word arrived with no command waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] != want.peek_data)
                    begin
                        $error("peek_data: expected %0h, got %0h", want.peek_data, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[8] != want.queue_empty)
                    begin
                        $error("queue_empty: expected %0d, got %0d", want.queue_empty, m_tdata[8]);
                        fail_count++;
                    end
                    if (m_tdata[16:9] != want.free_bytes)
                    begin
                        $error("free_bytes: expected %0d, got %0d", want.free_bytes, m_tdata[16:9]);
                        fail_count++;
                    end
                    if (m_tdata[23:17] != '0)
                    begin
                        $error("zero bits: expected 0, got %0h", m_tdata[23:17]);
                        fail_count++;
                    end
                end
            end
        end
        results_owed = pending_results.size();
    end

endmodule

@@ tb/length_prefixed_message_queue_core_tb.sv @@
// Top of the message queue testbench: clock, reset, command stimulus, receiver stalls and verdict.
module length_prefixed_message_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpmq_pkg::*;

    localparam int WORD_TARGET = 650;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // msg_length [7:0], data_byte [15:8], peek_offset [23:16]
    logic [S_DATA_W-1:0] s_tdata;
    // command [1:0]
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // peek_data [7:0], queue_empty [8], free_bytes [16:9], zero [23:17]
    logic [M_DATA_W-1:0] m_tdata;
    // status [2:0]
    logic [2:0]          m_tuser;
    int                  fail_count;
    int                  results_owed;

    int                  burst_left = 0;
    int                  words_sent = 0;

    length_prefixed_message_queue_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    length_prefixed_message_queue_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Presents one command word and waits for its acceptance; unused fields carry random bits.
    task automatic send_word(input cmd_t cmd, input logic [7:0] arg);
        logic [7:0] length;
        logic [7:0] payload;
        logic [7:0] offset;
        length  = 8'($urandom);
        payload = 8'($urandom);
        offset  = 8'($urandom);
        case (cmd)
            CMD_START: length  = arg;
            CMD_DATA:  payload = arg;
            CMD_PEEK:  offset  = arg;
            default:   ;
        endcase
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {offset, payload, length};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_interruption();
        case ($urandom_range(0, 2))
            0:       send_word(CMD_START, 8'($urandom));
            1:       send_word(CMD_POP, 8'($urandom));
            default: send_word(CMD_PEEK, 8'($urandom_range(0, 40)));
        endcase
    endtask

    // The receiver switches between always ready, light stalls and heavy stalls.
    initial
    begin
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left  = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(30, 120);
            end
            mode_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial
    begin
        int roll;
        int msg_len;
        int phase_left;
        int drain_wait;
        bit filling;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_START;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Guards on an empty queue, a message too long to fit, a zero-length message, an open message and stray data.
        send_word(CMD_PEEK, 8'd0);
        send_word(CMD_PEEK, 8'd255);
        send_word(CMD_POP, 8'd0);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_START, 8'd255);
        send_word(CMD_START, 8'd0);
        send_word(CMD_PEEK, 8'd0);
        send_word(CMD_PEEK, 8'd1);
        send_word(CMD_START, 8'd3);
        send_word(CMD_POP, 8'd0);
        send_word(CMD_POP, 8'd0);
        send_word(CMD_START, 8'd5);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_PEEK, 8'd2);
        send_word(CMD_DATA, 8'hA5);
        send_word(CMD_DATA, 8'h5A);
        send_word(CMD_PEEK, 8'd3);
        send_word(CMD_PEEK, 8'd4);
        send_word(CMD_POP, 8'd0);
        send_word(CMD_START, 8'd1);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_PEEK, 8'd1);
        send_word(CMD_POP, 8'd0);

        // Largest message that fits fills the ring completely.
        send_word(CMD_START, 8'd254);
        repeat (254) send_word(CMD_DATA, 8'($urandom));
        send_word(CMD_PEEK, 8'd254);
        send_word(CMD_PEEK, 8'd255);
        send_word(CMD_START, 8'd0);
        send_word(CMD_POP, 8'd0);

        filling    = 1'b1;
        phase_left = 0;
        while (words_sent < WORD_TARGET)
        begin
            if (phase_left <= 0)
            begin
                filling    = ~filling;
                phase_left = $urandom_range(40, 120);
            end
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 55 : 35))
            begin
                roll    = $urandom_range(0, 99);
                msg_len = (roll < 70) ? $urandom_range(0, 12) :
                          (roll < 95) ? $urandom_range(13, 60) : $urandom_range(61, 255);
                send_word(CMD_START, 8'(msg_len));
                for (int k = 0; k < msg_len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_interruption();
                    send_word(CMD_DATA, 8'($urandom));
                end
                phase_left -= msg_len + 1;
            end
            else if (roll < 70)
            begin
                repeat (filling ? 1 : $urandom_range(1, 3)) send_word(CMD_POP, 8'($urandom));
                phase_left--;
            end
            else if (roll < 85)
            begin
                send_word(CMD_PEEK, 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                                                   : $urandom));
                phase_left--;
            end
            else
            begin
                send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom));
                phase_left--;
            end
        end
        s_tvalid <= 1'b0;

        drain_wait = 0;
        while (results_owed != 0 && drain_wait < 5000)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (10) @(negedge clk);
        if (results_owed != 0)
            $error("%0d result words never arrived", results_owed);
        if (results_owed == 0 && fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
